// ----- rtl/core/chp_pkg.sv -----
// shared types and constants for the chunk header parser
package chp_pkg;

  localparam logic [23:0] TS_EXTENDED = 24'hFFFFFF;

  localparam logic [1:0] FMT_FULL      = 2'd0;
  localparam logic [1:0] FMT_NO_STREAM = 2'd1;
  localparam logic [1:0] FMT_TS_ONLY   = 2'd2;
  localparam logic [1:0] FMT_NONE      = 2'd3;

  // byte positions within one header
  localparam logic [3:0] PH_BASIC        = 4'd0;
  localparam logic [3:0] PH_TS_FIRST     = 4'd1;
  localparam logic [3:0] PH_TS_LAST      = 4'd3;
  localparam logic [3:0] PH_LEN_FIRST    = 4'd4;
  localparam logic [3:0] PH_LEN_LAST     = 4'd6;
  localparam logic [3:0] PH_TYPE         = 4'd7;
  localparam logic [3:0] PH_STREAM_FIRST = 4'd8;
  localparam logic [3:0] PH_EXT_SPAN     = 4'd4;

  localparam logic [5:0] CS_FIRST_VALID = 6'd2;

  typedef struct packed {
    logic [23:0] ts_field;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] stream;
    logic [31:0] abs_time;
  } chan_entry_t;

  // position of the last message header byte for a format
  function automatic logic [3:0] last_field_pos(input logic [1:0] f);
    logic [3:0] pos;
    unique case (f)
      FMT_FULL:      pos = 4'd11;
      FMT_NO_STREAM: pos = 4'd7;
      FMT_TS_ONLY:   pos = 4'd3;
      default:       pos = PH_BASIC;
    endcase
    return pos;
  endfunction

endpackage

// ----- rtl/core/chp_chan_table.sv -----
// per-channel header table: one synchronous memory with valid bits and write forwarding
module chp_chan_table #(
  parameter int CHANNELS = 64,
  parameter int AW       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output chp_pkg::chan_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  chp_pkg::chan_entry_t wr_data
);
  import chp_pkg::*;

  chan_entry_t           chan_mem_r [CHANNELS];
  logic [CHANNELS-1:0]   valid_r;
  chan_entry_t           rd_raw_r;
  chan_entry_t           rd_fwd_r;
  logic                  rd_sel_r;
  logic                  rd_valid_r;
  logic                  rd_hit;

  // a write to the address being read in the same cycle wins
  assign rd_hit = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      chan_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= chan_mem_r[rd_addr];
      rd_fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_sel_r   <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_sel_r   <= rd_hit;
        rd_valid_r <= valid_r[rd_addr] || rd_hit;
      end
    end
  end

  // entries never written since reset read as zero
  always_comb begin
    if (!rd_valid_r) begin
      rd_data = '0;
    end else if (rd_sel_r) begin
      rd_data = rd_fwd_r;
    end else begin
      rd_data = rd_raw_r;
    end
  end

endmodule

// ----- rtl/core/chunk_header_parser_core.sv -----
// chunk message header parser: top level with byte stage, channel table and result register
//
// in_* carries one header byte per transfer; out_* carries one result per finished header,
// or one error result (out_status = 1) for a chunk stream id of 0, 1 or CHANNELS and up.
// After an error all further bytes are taken and dropped until reset.
// Each accepted byte issues a table read at its low id bits; the read data lines up with
// the byte in the byte stage, where the header is assembled and, when done, unless FMT_NONE,
// written back with the new absolute timestamp (writes forward into a same-address read).
// Throughput: one byte per cycle unless stalled; the table has one read and one write port.
// The header's last byte is held in the byte stage, and its result is then registered in
// the output register that drives out_valid.
// A stalled result waits in the output register; the byte stage keeps taking bytes that
// produce no result and stalls the input only when it would need to emit another result.
// Reset: the parser expects a basic header, the halt flag clears and table entries read as
// zero through per-entry valid bits, so no clearing pass is needed and bytes are taken in
// the first cycle after reset.
module chunk_header_parser_core #(
  parameter int CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [5:0]  out_chunk_stream,
  output logic [1:0]  out_fmt,
  output logic [7:0]  out_msg_kind,
  output logic [23:0] out_msg_len,
  output logic [31:0] out_msg_stream,
  output logic [23:0] out_ts_field,
  output logic [31:0] out_timestamp
);
  import chp_pkg::*;

  localparam int AW = $clog2(CHANNELS);

  // byte stage
  logic        s2_valid_r;
  logic [7:0]  s2_byte_r;
  logic [3:0]  phase_r;
  logic        halted_r;

  // header under assembly
  logic [5:0]  w_cs_r;
  logic [1:0]  w_fmt_r;
  logic [23:0] w_ts_r;
  logic [23:0] w_len_r;
  logic [7:0]  w_type_r;
  logic [31:0] w_stream_r;
  logic [31:0] w_ext_r;
  logic [31:0] w_time_r;

  // result register
  logic        out_valid_r;
  logic        out_status_r;
  logic [5:0]  out_cs_r;
  logic [1:0]  out_fmt_r;
  logic [7:0]  out_type_r;
  logic [23:0] out_len_r;
  logic [31:0] out_stream_r;
  logic [23:0] out_ts_r;
  logic [31:0] out_time_r;

  chan_entry_t tbl_rd;
  chan_entry_t tbl_wr;
  logic        tbl_we;
  logic        in_xfer;

  logic        is_basic;
  logic [5:0]  cs_cur;
  logic [1:0]  fmt_cur;
  logic        cs_bad;
  logic [23:0] ts_nxt;
  logic [23:0] len_nxt;
  logic [7:0]  type_nxt;
  logic [31:0] stream_nxt;
  logic [31:0] ext_nxt;
  logic [31:0] time_nxt;
  logic [3:0]  end_k;
  logic        done;
  logic        err;
  logic        emit;
  logic        fire;
  logic        out_free;
  logic [31:0] abs_ts;

  always_comb begin
    is_basic   = (phase_r == PH_BASIC);
    cs_cur     = is_basic ? s2_byte_r[5:0] : w_cs_r;
    fmt_cur    = is_basic ? s2_byte_r[7:6] : w_fmt_r;
    cs_bad     = (cs_cur < CS_FIRST_VALID) || ({1'b0, cs_cur} >= 7'(CHANNELS));
    ts_nxt     = is_basic ? tbl_rd.ts_field : w_ts_r;
    len_nxt    = is_basic ? tbl_rd.len : w_len_r;
    type_nxt   = is_basic ? tbl_rd.mtype : w_type_r;
    stream_nxt = is_basic ? tbl_rd.stream : w_stream_r;
    time_nxt   = is_basic ? tbl_rd.abs_time : w_time_r;
    ext_nxt    = is_basic ? 32'd0 : w_ext_r;
    end_k      = last_field_pos(fmt_cur);

    if (!is_basic) begin
      if (phase_r <= end_k) begin
        if (phase_r == PH_TS_FIRST) begin
          ts_nxt = {16'd0, s2_byte_r};
        end else if (phase_r <= PH_TS_LAST) begin
          ts_nxt = {w_ts_r[15:0], s2_byte_r};
        end else if (phase_r == PH_LEN_FIRST) begin
          len_nxt = {16'd0, s2_byte_r};
        end else if (phase_r <= PH_LEN_LAST) begin
          len_nxt = {w_len_r[15:0], s2_byte_r};
        end else if (phase_r == PH_TYPE) begin
          type_nxt = s2_byte_r;
        end else if (phase_r == PH_STREAM_FIRST) begin
          stream_nxt = {24'd0, s2_byte_r};
        end else begin
          // little-endian stream id: byte lane follows the low phase bits
          stream_nxt = w_stream_r | ({24'd0, s2_byte_r} << {phase_r[1:0], 3'b000});
        end
      end else begin
        ext_nxt = {w_ext_r[23:0], s2_byte_r};
      end
    end

    done   = ((phase_r == end_k) && (ts_nxt != TS_EXTENDED)) ||
             (phase_r == 4'(end_k + PH_EXT_SPAN));
    abs_ts = ((ts_nxt == TS_EXTENDED) ? ext_nxt : {8'd0, ts_nxt}) +
             ((fmt_cur != FMT_FULL) ? time_nxt : 32'd0);
    err    = is_basic && cs_bad;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = s2_valid_r && !halted_r && (err || done);
  assign fire     = s2_valid_r && (!emit || out_free);
  assign in_stall = s2_valid_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  assign tbl_we          = fire && !halted_r && !err && done && (fmt_cur != FMT_NONE);
  assign tbl_wr.ts_field = ts_nxt;
  assign tbl_wr.len      = len_nxt;
  assign tbl_wr.mtype    = type_nxt;
  assign tbl_wr.stream   = stream_nxt;
  assign tbl_wr.abs_time = abs_ts;

  chp_chan_table #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_byte[AW-1:0]),
    .rd_data (tbl_rd),
    .wr_en   (tbl_we),
    .wr_addr (cs_cur[AW-1:0]),
    .wr_data (tbl_wr)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      phase_r     <= PH_BASIC;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire || in_xfer) begin
        s2_valid_r <= in_xfer;
      end
      if (fire && !halted_r) begin
        if (err) begin
          halted_r <= 1'b1;
        end else if (done) begin
          phase_r <= PH_BASIC;
        end else begin
          phase_r <= phase_r + 4'd1;
        end
      end
      if (out_free) begin
        out_valid_r <= fire && emit;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s2_byte_r <= in_byte;
    end
    if (fire && !halted_r) begin
      w_cs_r     <= cs_cur;
      w_fmt_r    <= fmt_cur;
      w_ts_r     <= ts_nxt;
      w_len_r    <= len_nxt;
      w_type_r   <= type_nxt;
      w_stream_r <= stream_nxt;
      w_ext_r    <= ext_nxt;
      w_time_r   <= time_nxt;
    end
    if (fire && emit) begin
      out_status_r <= err;
      out_cs_r     <= cs_cur;
      out_fmt_r    <= fmt_cur;
      out_type_r   <= err ? 8'd0 : type_nxt;
      out_len_r    <= err ? 24'd0 : len_nxt;
      out_stream_r <= err ? 32'd0 : stream_nxt;
      out_ts_r     <= err ? 24'd0 : ts_nxt;
      out_time_r   <= err ? 32'd0 : abs_ts;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chunk_stream = out_cs_r;
  assign out_fmt          = out_fmt_r;
  assign out_msg_kind     = out_type_r;
  assign out_msg_len      = out_len_r;
  assign out_msg_stream   = out_stream_r;
  assign out_ts_field     = out_ts_r;
  assign out_timestamp    = out_time_r;

endmodule
